// ===== src/sgcs_pkg.sv =====
// Shared types and constants for the scatter-gather copy splitter.
package sgcs_pkg;

    localparam int DEF_MAX_SEGS  = 64;
    localparam int DEF_MAX_BATCH = 32;

    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 32;
    localparam int LIMIT_W = 6;
    localparam int CNT_W   = 6;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0]   RST_MAX_XFER    = 32'd2097152;
    localparam logic [LIMIT_W-1:0] RST_BATCH_LIMIT = 6'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_XFER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LIM  = 2'd2;

    typedef enum logic [1:0] {
        KIND_ENTRY  = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_HEADER = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_DECIDE,
        S_ENTRY,
        S_ADV,
        S_DLOAD,
        S_SLOAD,
        S_HDR
    } t_state;

    typedef struct packed {
        logic  take;
        logic  emit;
        t_kind kind;
        logic  load_first;
        logic  step;
        logic  inc_di;
        logic  inc_si;
        logic  load_d;
        logic  load_s;
        logic  clear;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic reject;
        logic single;
        logic adv_dst;
        logic adv_src;
        logic merge_done;
        logic out_free;
    } t_status;

endpackage

// ===== src/sgcs_ctrl.sv =====
// Sequencing state machine for list loading, checking and descriptor merge.
module sgcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sgcs_pkg::t_status i_st,
    output sgcs_pkg::t_cmd    o_cmd
);

    sgcs_pkg::t_state r_state;
    sgcs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgcs_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgcs_pkg::S_LOAD: begin
                if (i_st.close) n_state = sgcs_pkg::S_FETCH;
            end
            sgcs_pkg::S_FETCH: begin
                n_state = sgcs_pkg::S_DECIDE;
            end
            sgcs_pkg::S_DECIDE: begin
                if (i_st.out_free) begin
                    if (i_st.reject || i_st.single) n_state = sgcs_pkg::S_LOAD;
                    else n_state = sgcs_pkg::S_ENTRY;
                end
            end
            sgcs_pkg::S_ENTRY: begin
                if (i_st.out_free) n_state = sgcs_pkg::S_ADV;
            end
            sgcs_pkg::S_ADV: begin
                priority if (i_st.adv_dst) n_state = sgcs_pkg::S_DLOAD;
                else if (i_st.adv_src) n_state = sgcs_pkg::S_SLOAD;
                else if (i_st.merge_done) n_state = sgcs_pkg::S_HDR;
                else n_state = sgcs_pkg::S_ENTRY;
            end
            sgcs_pkg::S_DLOAD: n_state = sgcs_pkg::S_ADV;
            sgcs_pkg::S_SLOAD: n_state = sgcs_pkg::S_ADV;
            sgcs_pkg::S_HDR: begin
                if (i_st.out_free) n_state = sgcs_pkg::S_LOAD;
            end
            default: n_state = sgcs_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.kind = sgcs_pkg::KIND_ENTRY;
        unique case (r_state)
            sgcs_pkg::S_LOAD: o_cmd.take = 1'b1;
            sgcs_pkg::S_FETCH: ;
            sgcs_pkg::S_DECIDE: begin
                if (i_st.out_free) begin
                    priority if (i_st.reject) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.kind  = sgcs_pkg::KIND_REJECT;
                        o_cmd.clear = 1'b1;
                    end else if (i_st.single) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.kind  = sgcs_pkg::KIND_SINGLE;
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.load_first = 1'b1;
                    end
                end
            end
            sgcs_pkg::S_ENTRY: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = sgcs_pkg::KIND_ENTRY;
                    o_cmd.step = 1'b1;
                end
            end
            sgcs_pkg::S_ADV: begin
                priority if (i_st.adv_dst) o_cmd.inc_di = 1'b1;
                else if (i_st.adv_src) o_cmd.inc_si = 1'b1;
            end
            sgcs_pkg::S_DLOAD: o_cmd.load_d = 1'b1;
            sgcs_pkg::S_SLOAD: o_cmd.load_s = 1'b1;
            sgcs_pkg::S_HDR: begin
                if (i_st.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.kind  = sgcs_pkg::KIND_HEADER;
                    o_cmd.clear = 1'b1;
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_emit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_st.out_free) else $error("word emitted into a busy output register");
    a_clear_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> (r_state == sgcs_pkg::S_LOAD)) else $error("request closed but not idle");
    a_take_no_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> !o_cmd.emit) else $error("loading while emitting");
`endif

endmodule

// ===== src/sgcs_datapath.sv =====
// Segment stores, list counters, merge registers and output register.
module sgcs_datapath #(
    parameter int MAX_SEGS  = sgcs_pkg::DEF_MAX_SEGS,
    parameter int MAX_BATCH = sgcs_pkg::DEF_MAX_BATCH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sgcs_pkg::t_cmd                      i_cmd,
    output sgcs_pkg::t_status                   o_st,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_from_source,
    input  logic [sgcs_pkg::ADDR_W-1:0]         i_seg_addr,
    input  logic [sgcs_pkg::LEN_W-1:0]          i_seg_len,
    input  logic                                i_end_of_list,
    input  logic                                i_want_interrupt,
    input  logic                                i_cfg_wr_en,
    input  logic [sgcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sgcs_pkg::CFG_W-1:0]          i_cfg_wdata,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_kind,
    output logic [sgcs_pkg::ADDR_W-1:0]         o_src_addr,
    output logic [sgcs_pkg::ADDR_W-1:0]         o_dst_addr,
    output logic [sgcs_pkg::LEN_W-1:0]          o_xfer_len,
    output logic [sgcs_pkg::CNT_W-1:0]          o_entry_count,
    output logic                                o_irq_request,
    output logic                                o_last
);

    localparam int IW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam int CW = $clog2(MAX_SEGS + 1);
    localparam int LW = (CW > sgcs_pkg::LIMIT_W) ? CW : sgcs_pkg::LIMIT_W;
    localparam int MW = sgcs_pkg::ADDR_W + sgcs_pkg::LEN_W;
    localparam logic [CW-1:0] SEG_CAP = CW'(MAX_SEGS);
    localparam logic [sgcs_pkg::LIMIT_W-1:0] BATCH_CAP = sgcs_pkg::LIMIT_W'(MAX_BATCH);

    // configuration
    logic                           r_queue_en;
    logic [sgcs_pkg::LEN_W-1:0]     r_max_xfer;
    logic [sgcs_pkg::LIMIT_W-1:0]   r_batch_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_en    <= 1'b0;
            r_max_xfer    <= sgcs_pkg::RST_MAX_XFER;
            r_batch_limit <= sgcs_pkg::RST_BATCH_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sgcs_pkg::CFG_QUEUE_EN:  r_queue_en    <= i_cfg_wdata[0];
                sgcs_pkg::CFG_MAX_XFER:  r_max_xfer    <= i_cfg_wdata[sgcs_pkg::LEN_W-1:0];
                sgcs_pkg::CFG_BATCH_LIM: r_batch_limit <= i_cfg_wdata[sgcs_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // list loading
    logic [CW-1:0] r_dcnt, r_scnt;
    logic          r_dst_ended, r_src_ended, r_ovf, r_irq;
    logic          w_live, w_close, w_wr_d, w_wr_s;

    assign o_in_ready = i_cmd.take;
    assign w_live  = i_in_valid && i_cmd.take &&
                     !(i_from_source ? r_src_ended : r_dst_ended);
    assign w_close = w_live && i_end_of_list &&
                     (i_from_source ? r_dst_ended : r_src_ended);
    assign w_wr_d  = w_live && !i_from_source && (r_dcnt < SEG_CAP);
    assign w_wr_s  = w_live && i_from_source && (r_scnt < SEG_CAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_dcnt      <= '0;
            r_scnt      <= '0;
            r_dst_ended <= 1'b0;
            r_src_ended <= 1'b0;
            r_ovf       <= 1'b0;
        end else if (w_live) begin
            if (i_from_source) begin
                if (w_wr_s) r_scnt <= r_scnt + CW'(1);
                else r_ovf <= 1'b1;
                if (i_end_of_list) r_src_ended <= 1'b1;
            end else begin
                if (w_wr_d) r_dcnt <= r_dcnt + CW'(1);
                else r_ovf <= 1'b1;
                if (i_end_of_list) r_dst_ended <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_close) r_irq <= i_want_interrupt;
    end

    // segment stores: {address, length}
    logic [MW-1:0] r_dst_mem [MAX_SEGS];
    logic [MW-1:0] r_src_mem [MAX_SEGS];
    logic [MW-1:0] r_dst_rd, r_src_rd;
    logic [IW-1:0] r_di, r_si, n_di, n_si;

    always_comb begin
        n_di = r_di;
        n_si = r_si;
        if (i_cmd.clear) begin
            n_di = '0;
            n_si = '0;
        end else begin
            if (i_cmd.inc_di) n_di = r_di + IW'(1);
            if (i_cmd.inc_si) n_si = r_si + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_di <= '0;
            r_si <= '0;
        end else begin
            r_di <= n_di;
            r_si <= n_si;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_d) r_dst_mem[r_dcnt[IW-1:0]] <= {i_seg_addr, i_seg_len};
        r_dst_rd <= r_dst_mem[n_di];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_s) r_src_mem[r_scnt[IW-1:0]] <= {i_seg_addr, i_seg_len};
        r_src_rd <= r_src_mem[n_si];
    end

    logic [sgcs_pkg::ADDR_W-1:0] w_drd_addr, w_srd_addr;
    logic [sgcs_pkg::LEN_W-1:0]  w_drd_len, w_srd_len;
    assign w_drd_addr = r_dst_rd[MW-1:sgcs_pkg::LEN_W];
    assign w_drd_len  = r_dst_rd[sgcs_pkg::LEN_W-1:0];
    assign w_srd_addr = r_src_rd[MW-1:sgcs_pkg::LEN_W];
    assign w_srd_len  = r_src_rd[sgcs_pkg::LEN_W-1:0];

    // request checks
    logic [sgcs_pkg::LIMIT_W-1:0] w_lim;
    logic [CW-1:0]                w_mn;
    logic                         w_single, w_list_bad, w_single_bad;

    assign w_lim = (r_batch_limit > BATCH_CAP) ? BATCH_CAP : r_batch_limit;
    assign w_mn  = (r_dcnt < r_scnt) ? r_dcnt : r_scnt;
    assign w_single   = (r_dcnt == CW'(1)) && (r_scnt == CW'(1));
    assign w_list_bad = r_ovf || (r_dcnt == '0) || (r_scnt == '0) ||
                        (LW'(w_mn) > LW'(w_lim));
    assign w_single_bad = w_single && ((w_drd_len != w_srd_len) ||
                          (w_drd_len > r_max_xfer) || !r_queue_en);

    // merge walk
    logic [sgcs_pkg::ADDR_W-1:0] r_dptr, r_sptr;
    logic [sgcs_pkg::LEN_W-1:0]  r_drem, r_srem, w_len, w_min_rem;
    logic [sgcs_pkg::CNT_W-1:0]  r_n;

    assign w_min_rem = (r_drem < r_srem) ? r_drem : r_srem;
    assign w_len     = (w_min_rem < r_max_xfer) ? w_min_rem : r_max_xfer;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first) begin
            r_dptr <= w_drd_addr;
            r_drem <= w_drd_len;
            r_sptr <= w_srd_addr;
            r_srem <= w_srd_len;
        end else if (i_cmd.step) begin
            r_dptr <= r_dptr + sgcs_pkg::ADDR_W'(w_len);
            r_drem <= r_drem - w_len;
            r_sptr <= r_sptr + sgcs_pkg::ADDR_W'(w_len);
            r_srem <= r_srem - w_len;
        end else begin
            if (i_cmd.load_d) begin
                r_dptr <= w_drd_addr;
                r_drem <= w_drd_len;
            end
            if (i_cmd.load_s) begin
                r_sptr <= w_srd_addr;
                r_srem <= w_srd_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear || i_cmd.load_first) begin
            r_n <= '0;
        end else if (i_cmd.step) begin
            r_n <= r_n + sgcs_pkg::CNT_W'(1);
        end
    end

    // output register
    logic r_out_valid;
    logic [1:0] r_kind;
    logic [sgcs_pkg::ADDR_W-1:0] r_src_addr, r_dst_addr;
    logic [sgcs_pkg::LEN_W-1:0]  r_xfer_len;
    logic [sgcs_pkg::CNT_W-1:0]  r_entry_count;
    logic r_irq_req, r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind        <= i_cmd.kind;
            r_src_addr    <= '0;
            r_dst_addr    <= '0;
            r_xfer_len    <= '0;
            r_entry_count <= '0;
            r_irq_req     <= 1'b0;
            r_last        <= 1'b1;
            unique case (i_cmd.kind)
                sgcs_pkg::KIND_ENTRY: begin
                    r_src_addr <= r_sptr;
                    r_dst_addr <= r_dptr;
                    r_xfer_len <= w_len;
                    r_last     <= 1'b0;
                end
                sgcs_pkg::KIND_SINGLE: begin
                    r_src_addr <= w_srd_addr;
                    r_dst_addr <= w_drd_addr;
                    r_xfer_len <= w_drd_len;
                    r_irq_req  <= r_irq;
                end
                sgcs_pkg::KIND_HEADER: begin
                    r_entry_count <= r_n;
                    r_irq_req     <= r_irq;
                end
                sgcs_pkg::KIND_REJECT: ;
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_src_addr    = r_src_addr;
    assign o_dst_addr    = r_dst_addr;
    assign o_xfer_len    = r_xfer_len;
    assign o_entry_count = r_entry_count;
    assign o_irq_request = r_irq_req;
    assign o_last        = r_last;

    // status
    always_comb begin
        o_st.close      = w_close;
        o_st.reject     = w_list_bad || w_single_bad;
        o_st.single     = w_single;
        o_st.adv_dst    = (r_drem == '0) && ((CW'(r_di) + CW'(1)) < r_dcnt);
        o_st.adv_src    = (r_srem == '0) && ((CW'(r_si) + CW'(1)) < r_scnt);
        o_st.merge_done = (r_drem == '0) || (r_srem == '0) ||
                          (LW'(r_n) >= LW'(w_lim));
        o_st.out_free   = !r_out_valid || i_out_ready;
    end

`ifndef NO_ASSERTIONS
    a_cnt_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dcnt <= SEG_CAP) && (r_scnt <= SEG_CAP)) else $error("list count past store depth");
    a_batch_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (LW'(r_n) < LW'(BATCH_CAP))) else $error("entry beyond batch cap");
    a_index_in_list : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.inc_di |-> ((CW'(r_di) + CW'(1)) < r_dcnt)) else $error("dst walk past list end");
`endif

endmodule

// ===== src/scatter_gather_copy_splitter_unit.sv =====
// Top level of the scatter-gather copy splitter: controller plus datapath.
//
// The block collects a destination and a source scatter list, one segment
// word per cycle while it sits in its load phase. The word that closes the
// second list starts the request: the block reads the first segment of each
// list, then emits either one reject word, one single-copy word, or a run of
// batch entries followed by a batch header carrying the entry count. After
// the closing word the block reads the segment stores, then checks the
// request before the first result. Each batch entry passes through an entry
// state and an advance state, and each step onto a following segment of
// either list adds one registered read of that list's segment store. No
// new segment word is taken until the request's last result has gone into
// the output register; that register lets the next request start loading
// while its final word still waits to be taken. Configuration is written on
// a plain write port and must only change while the block is idle.
module scatter_gather_copy_splitter_unit #(
    parameter int MAX_SEGS  = sgcs_pkg::DEF_MAX_SEGS,
    parameter int MAX_BATCH = sgcs_pkg::DEF_MAX_BATCH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // segment words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_from_source,
    input  logic [sgcs_pkg::ADDR_W-1:0]    i_seg_addr,
    input  logic [sgcs_pkg::LEN_W-1:0]     i_seg_len,
    input  logic                           i_end_of_list,
    input  logic                           i_want_interrupt,
    // configuration writes
    input  logic                           i_cfg_wr_en,
    input  logic [sgcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sgcs_pkg::CFG_W-1:0]     i_cfg_wdata,
    // descriptor words
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_kind,
    output logic [sgcs_pkg::ADDR_W-1:0]    o_src_addr,
    output logic [sgcs_pkg::ADDR_W-1:0]    o_dst_addr,
    output logic [sgcs_pkg::LEN_W-1:0]     o_xfer_len,
    output logic [sgcs_pkg::CNT_W-1:0]     o_entry_count,
    output logic                           o_irq_request,
    output logic                           o_last
);

    sgcs_pkg::t_cmd    w_cmd;
    sgcs_pkg::t_status w_st;

    // sequence load, check, merge and header
    sgcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    // hold the lists, walk them and register each result word
    sgcs_datapath #(
        .MAX_SEGS  (MAX_SEGS),
        .MAX_BATCH (MAX_BATCH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_st             (w_st),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_from_source    (i_from_source),
        .i_seg_addr       (i_seg_addr),
        .i_seg_len        (i_seg_len),
        .i_end_of_list    (i_end_of_list),
        .i_want_interrupt (i_want_interrupt),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_src_addr       (o_src_addr),
        .o_dst_addr       (o_dst_addr),
        .o_xfer_len       (o_xfer_len),
        .o_entry_count    (o_entry_count),
        .o_irq_request    (o_irq_request),
        .o_last           (o_last)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the scatter-gather copy splitter: table-driven directed words, then random requests.
module tb_top;
    import sgcs_pkg::*;

    localparam int SEG_DEPTH   = DEF_MAX_SEGS;
    localparam int BATCH_DEPTH = DEF_MAX_BATCH;
    localparam int MAX_GAP     = 17;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASE_WORDS = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_CAP   = 40;

    localparam logic LIST_DST = 1'b0;
    localparam logic LIST_SRC = 1'b1;

    localparam logic [ADDR_W-1:0] BASE_DST = 64'h0000_1000_0000_0000;
    localparam logic [ADDR_W-1:0] BASE_SRC = 64'h0000_2000_0000_0040;

    typedef struct {
        logic              from_src;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic              eol;
        logic              irq;
    } seg_word_t;

    typedef struct {
        t_kind             kind;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [LEN_W-1:0]  len;
        logic [CNT_W-1:0]  cnt;
        logic              irq;
        logic              last;
    } descr_t;

    typedef enum logic { ROW_SEG, ROW_CFG } row_op_t;

    typedef struct {
        row_op_t              op;
        seg_word_t            seg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [CFG_W-1:0]     cfg_data;
        logic                 typed;
        descr_t               want;
    } stim_row_t;

    // DUT-facing signals, inputs all known from time zero
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_ready;
    logic                 i_from_source    = 1'b0;
    logic [ADDR_W-1:0]    i_seg_addr       = '0;
    logic [LEN_W-1:0]     i_seg_len        = '0;
    logic                 i_end_of_list    = 1'b0;
    logic                 i_want_interrupt = 1'b0;
    logic                 i_cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [CFG_W-1:0]     i_cfg_wdata      = '0;
    logic                 o_out_valid;
    logic                 i_out_ready      = 1'b0;
    logic [1:0]           o_kind;
    logic [ADDR_W-1:0]    o_src_addr;
    logic [ADDR_W-1:0]    o_dst_addr;
    logic [LEN_W-1:0]     o_xfer_len;
    logic [CNT_W-1:0]     o_entry_count;
    logic                 o_irq_request;
    logic                 o_last;

    scatter_gather_copy_splitter_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_from_source    (i_from_source),
        .i_seg_addr       (i_seg_addr),
        .i_seg_len        (i_seg_len),
        .i_end_of_list    (i_end_of_list),
        .i_want_interrupt (i_want_interrupt),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_src_addr       (o_src_addr),
        .o_dst_addr       (o_dst_addr),
        .o_xfer_len       (o_xfer_len),
        .o_entry_count    (o_entry_count),
        .o_irq_request    (o_irq_request),
        .o_last           (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the segment stores, list state and registers
    logic [ADDR_W-1:0]  dst_addr_st [SEG_DEPTH];
    logic [LEN_W-1:0]   dst_len_st  [SEG_DEPTH];
    logic [ADDR_W-1:0]  src_addr_st [SEG_DEPTH];
    logic [LEN_W-1:0]   src_len_st  [SEG_DEPTH];
    int                 dst_segs       = 0;
    int                 src_segs       = 0;
    bit                 dst_closed     = 1'b0;
    bit                 src_closed     = 1'b0;
    bit                 store_overflow = 1'b0;
    bit                 cfg_queue_en   = 1'b0;
    logic [LEN_W-1:0]   cfg_max_xfer   = RST_MAX_XFER;
    logic [LIMIT_W-1:0] cfg_batch_lim  = RST_BATCH_LIMIT;

    descr_t pending_descr[$];   // descriptors still owed by the block, oldest first
    descr_t new_descr[$];       // descriptors caused by the latest word
    descr_t head_descr;
    descr_t no_descr;
    int     mismatches = 0;
    int     words_sent = 0;
    bit     quiet      = 1'b0;  // no idling on either side while set
    int     rx_hold    = 0;     // one-shot long stall request for the sink

    function automatic descr_t make_descr(t_kind kind, logic [ADDR_W-1:0] src,
                                          logic [ADDR_W-1:0] dst, logic [LEN_W-1:0] len,
                                          logic [CNT_W-1:0] cnt, logic irq, logic last);
        descr_t d;
        d.kind = kind;
        d.src  = src;
        d.dst  = dst;
        d.len  = len;
        d.cnt  = cnt;
        d.irq  = irq;
        d.last = last;
        return d;
    endfunction

    // Check both closed lists, then emit a reject, a single copy, or a batch.
    function automatic void split_request(logic irq);
        int                lim;
        int                fewer;
        int                di;
        int                si;
        int                n;
        logic [ADDR_W-1:0] d_left;
        logic [ADDR_W-1:0] s_left;
        logic [ADDR_W-1:0] step;
        logic [ADDR_W-1:0] d_at;
        logic [ADDR_W-1:0] s_at;
        lim   = (cfg_batch_lim > BATCH_DEPTH) ? BATCH_DEPTH : int'(cfg_batch_lim);
        fewer = (dst_segs < src_segs) ? dst_segs : src_segs;
        if (store_overflow || dst_segs == 0 || src_segs == 0 || fewer > lim) begin
            new_descr.push_back(make_descr(KIND_REJECT, '0, '0, '0, '0, 1'b0, 1'b1));
            return;
        end
        d_left = 64'(dst_len_st[0]);
        s_left = 64'(src_len_st[0]);
        if (dst_segs == 1 && src_segs == 1) begin
            if (d_left != s_left || d_left > 64'(cfg_max_xfer) || !cfg_queue_en)
                new_descr.push_back(make_descr(KIND_REJECT, '0, '0, '0, '0, 1'b0, 1'b1));
            else
                new_descr.push_back(make_descr(KIND_SINGLE, src_addr_st[0], dst_addr_st[0],
                                               dst_len_st[0], '0, irq, 1'b1));
            return;
        end
        di = 0;
        si = 0;
        n  = 0;
        while (n < lim) begin
            // the next entry starts where the unused part of each segment begins
            d_at = dst_addr_st[di] + 64'(dst_len_st[di]) - d_left;
            s_at = src_addr_st[si] + 64'(src_len_st[si]) - s_left;
            step = (d_left < s_left) ? d_left : s_left;
            if (64'(cfg_max_xfer) < step)
                step = 64'(cfg_max_xfer);
            new_descr.push_back(make_descr(KIND_ENTRY, s_at, d_at, step[LEN_W-1:0], '0,
                                           1'b0, 1'b0));
            n++;
            d_left -= step;
            while (d_left == 0 && di + 1 < dst_segs) begin
                di++;
                d_left = 64'(dst_len_st[di]);
            end
            s_left -= step;
            while (s_left == 0 && si + 1 < src_segs) begin
                si++;
                s_left = 64'(src_len_st[si]);
            end
            if (d_left == 0 || s_left == 0)
                break;
        end
        new_descr.push_back(make_descr(KIND_HEADER, '0, '0, '0, CNT_W'(n), irq, 1'b1));
    endfunction

    // Store one accepted segment word; close the request once both lists end.
    function automatic void load_segment(seg_word_t w);
        new_descr.delete();
        if (w.from_src == LIST_SRC) begin
            if (src_closed)
                return;
            if (src_segs < SEG_DEPTH) begin
                src_addr_st[src_segs] = w.addr;
                src_len_st[src_segs]  = w.len;
                src_segs++;
            end else begin
                store_overflow = 1'b1;
            end
            if (w.eol)
                src_closed = 1'b1;
        end else begin
            if (dst_closed)
                return;
            if (dst_segs < SEG_DEPTH) begin
                dst_addr_st[dst_segs] = w.addr;
                dst_len_st[dst_segs]  = w.len;
                dst_segs++;
            end else begin
                store_overflow = 1'b1;
            end
            if (w.eol)
                dst_closed = 1'b1;
        end
        if (dst_closed && src_closed) begin
            split_request(w.irq);
            dst_segs       = 0;
            src_segs       = 0;
            dst_closed     = 1'b0;
            src_closed     = 1'b0;
            store_overflow = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Offer one word after a random gap; hold it until taken, then predict.
    // Called and returns at a falling edge; valid stays high for a back-to-back word.
    task automatic send_word(seg_word_t w, logic typed, descr_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_from_source    <= w.from_src;
        i_seg_addr       <= w.addr;
        i_seg_len        <= w.len;
        i_end_of_list    <= w.eol;
        i_want_interrupt <= w.irq;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        load_segment(w);
        if (typed)
            pending_descr.push_back(want);
        else
            foreach (new_descr[k])
                pending_descr.push_back(new_descr[k]);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every owed descriptor, then let the block go idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_descr.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_QUEUE_EN:  cfg_queue_en  = data[0];
            CFG_MAX_XFER:  cfg_max_xfer  = data;
            CFG_BATCH_LIM: cfg_batch_lim = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic q_en, logic [LEN_W-1:0] max_xfer,
                              logic [LIMIT_W-1:0] lim);
        settle();
        cfg_write(CFG_QUEUE_EN, CFG_W'(q_en));
        cfg_write(CFG_MAX_XFER, max_xfer);
        cfg_write(CFG_BATCH_LIM, CFG_W'(lim));
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Send one well-formed request: both lists interleaved at random, each closed by
    // its end mark. With noisy set, stray words for an already closed list slip in.
    task automatic run_request(int n_dst, int n_src, bit same_lens, bit noisy);
        logic [LEN_W-1:0] dst_lens[$];
        logic [LEN_W-1:0] src_lens[$];
        int               di;
        int               si;
        seg_word_t        w;
        for (int k = 0; k < n_dst; k++)
            dst_lens.push_back(pick_len());
        for (int k = 0; k < n_src; k++)
            src_lens.push_back((same_lens && k < n_dst) ? dst_lens[k] : pick_len());
        di = 0;
        si = 0;
        while (di < n_dst || si < n_src) begin
            if (di == n_dst)
                w.from_src = LIST_SRC;
            else if (si == n_src)
                w.from_src = LIST_DST;
            else
                w.from_src = $urandom_range(0, 1);
            w.addr = pick_addr();
            w.irq  = $urandom_range(0, 1);
            if (w.from_src == LIST_SRC) begin
                w.len = src_lens[si];
                si++;
                w.eol = (si == n_src);
            end else begin
                w.len = dst_lens[di];
                di++;
                w.eol = (di == n_dst);
            end
            send_word(w, 1'b0, no_descr);
            // stray word for the list that has ended while the other is open
            if (noisy && (di == n_dst) != (si == n_src) && $urandom_range(0, 2) == 0) begin
                w.from_src = (si == n_src) ? LIST_SRC : LIST_DST;
                w.addr     = pick_addr();
                w.len      = pick_len();
                w.eol      = $urandom_range(0, 1);
                w.irq      = $urandom_range(0, 1);
                send_word(w, 1'b0, no_descr);
            end
        end
        words_sent += n_dst + n_src;
    endtask

    function automatic stim_row_t seg_row(logic from_src, logic [ADDR_W-1:0] addr,
                                          logic [LEN_W-1:0] len, logic eol, logic irq);
        stim_row_t r;
        r.op           = ROW_SEG;
        r.seg.from_src = from_src;
        r.seg.addr     = addr;
        r.seg.len      = len;
        r.seg.eol      = eol;
        r.seg.irq      = irq;
        r.cfg_idx      = '0;
        r.cfg_data     = '0;
        r.typed        = 1'b0;
        r.want         = make_descr(KIND_ENTRY, '0, '0, '0, '0, 1'b0, 1'b0);
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        stim_row_t r;
        r          = seg_row(LIST_DST, '0, '0, 1'b0, 1'b0);
        r.op       = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        return r;
    endfunction

    // Attach a hand-written final result to a row that closes a request.
    function automatic stim_row_t expecting(stim_row_t r, t_kind kind, logic [ADDR_W-1:0] src,
                                            logic [ADDR_W-1:0] dst, logic [LEN_W-1:0] len,
                                            logic irq);
        r.typed = 1'b1;
        r.want  = make_descr(kind, src, dst, len, '0, irq, 1'b1);
        return r;
    endfunction

    // Descriptor sink: random stall per word, plus one long hold on request.
    initial begin : descr_sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold != 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // Compare every taken descriptor word against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_descr.size() == 0) begin
                report_mismatch("unexpected word, kind", 64'(o_kind), '0);
            end else begin
                head_descr = pending_descr.pop_front();
                if (o_kind !== head_descr.kind)
                    report_mismatch("kind", 64'(o_kind), 64'(head_descr.kind));
                if (o_src_addr !== head_descr.src)
                    report_mismatch("src_addr", o_src_addr, head_descr.src);
                if (o_dst_addr !== head_descr.dst)
                    report_mismatch("dst_addr", o_dst_addr, head_descr.dst);
                if (o_xfer_len !== head_descr.len)
                    report_mismatch("xfer_len", 64'(o_xfer_len), 64'(head_descr.len));
                if (o_entry_count !== head_descr.cnt)
                    report_mismatch("entry_count", 64'(o_entry_count), 64'(head_descr.cnt));
                if (o_irq_request !== head_descr.irq)
                    report_mismatch("irq_request", 64'(o_irq_request), 64'(head_descr.irq));
                if (o_last !== head_descr.last)
                    report_mismatch("last", 64'(o_last), 64'(head_descr.last));
            end
        end
    end

    initial begin : stimulus
        stim_row_t rows[$];
        int        start;
        int        shape;
        bit        noisy;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, starting from reset values (queue disabled)
        rows.push_back(seg_row(LIST_DST, BASE_DST, 32'd100, 1'b1, 1'b0));
        rows.push_back(expecting(seg_row(LIST_SRC, BASE_SRC, 32'd100, 1'b1, 1'b1),
                                 KIND_REJECT, '0, '0, '0, 1'b0));
        rows.push_back(cfg_row(CFG_QUEUE_EN, 32'd1));
        // single copy, source list closed first
        rows.push_back(seg_row(LIST_SRC, BASE_SRC, 32'd100, 1'b1, 1'b0));
        rows.push_back(expecting(seg_row(LIST_DST, BASE_DST, 32'd100, 1'b1, 1'b1),
                                 KIND_SINGLE, BASE_SRC, BASE_DST, 32'd100, 1'b1));
        // lengths differ
        rows.push_back(seg_row(LIST_DST, BASE_DST, 32'd64, 1'b1, 1'b0));
        rows.push_back(expecting(seg_row(LIST_SRC, BASE_SRC, 32'd65, 1'b1, 1'b1),
                                 KIND_REJECT, '0, '0, '0, 1'b0));
        // length right at the limit; the stray destination word is dropped
        rows.push_back(seg_row(LIST_DST, '1, RST_MAX_XFER, 1'b1, 1'b0));
        rows.push_back(seg_row(LIST_DST, 64'h5, 32'd7, 1'b0, 1'b1));
        rows.push_back(expecting(seg_row(LIST_SRC, '0, RST_MAX_XFER, 1'b1, 1'b0),
                                 KIND_SINGLE, '0, '1, RST_MAX_XFER, 1'b0));
        // one byte over the limit
        rows.push_back(seg_row(LIST_DST, BASE_DST, RST_MAX_XFER + 32'd1, 1'b1, 1'b0));
        rows.push_back(expecting(seg_row(LIST_SRC, BASE_SRC, RST_MAX_XFER + 32'd1, 1'b1, 1'b1),
                                 KIND_REJECT, '0, '0, '0, 1'b0));
        // merge with a zero-length first segment and a split source
        rows.push_back(seg_row(LIST_DST, BASE_DST, 32'd0, 1'b0, 1'b0));
        rows.push_back(seg_row(LIST_DST, BASE_DST + 64'h100, 32'd50, 1'b1, 1'b0));
        rows.push_back(seg_row(LIST_SRC, BASE_SRC, 32'd30, 1'b0, 1'b0));
        rows.push_back(seg_row(LIST_SRC, BASE_SRC + 64'h200, 32'd20, 1'b1, 1'b1));
        // zero transfer limit: zero-length entries until the batch limit
        rows.push_back(cfg_row(CFG_MAX_XFER, 32'd0));
        rows.push_back(cfg_row(CFG_BATCH_LIM, 32'd3));
        rows.push_back(seg_row(LIST_DST, BASE_DST, 32'd10, 1'b0, 1'b0));
        rows.push_back(seg_row(LIST_SRC, BASE_SRC, 32'd10, 1'b1, 1'b0));
        rows.push_back(seg_row(LIST_DST, BASE_DST + 64'd10, 32'd10, 1'b1, 1'b1));
        // batch limit of zero rejects everything
        rows.push_back(cfg_row(CFG_BATCH_LIM, 32'd0));
        rows.push_back(seg_row(LIST_DST, BASE_DST, 32'd8, 1'b1, 1'b0));
        rows.push_back(expecting(seg_row(LIST_SRC, BASE_SRC, 32'd8, 1'b1, 1'b1),
                                 KIND_REJECT, '0, '0, '0, 1'b0));
        // widest length and addresses at both ends, saturating batch limit
        rows.push_back(cfg_row(CFG_MAX_XFER, '1));
        rows.push_back(cfg_row(CFG_BATCH_LIM, 32'd63));
        rows.push_back(seg_row(LIST_SRC, '1, '1, 1'b1, 1'b0));
        rows.push_back(expecting(seg_row(LIST_DST, '0, '1, 1'b1, 1'b1),
                                 KIND_SINGLE, '1, '0, '1, 1'b1));

        foreach (rows[r]) begin
            if (rows[r].op == ROW_CFG) begin
                settle();
                cfg_write(rows[r].cfg_idx, rows[r].cfg_data);
            end else begin
                send_word(rows[r].seg, rows[r].typed, rows[r].want);
            end
        end

        // Random part: one register setting per phase
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(1'b1, RST_MAX_XFER, 6'd32);
                1: set_config(1'b0, 32'd64, 6'd2);
                2: set_config(1'b1, 32'd1, 6'd63);
                3: set_config(1'b1, '1, 6'd1);
                4: set_config(1'b1, $urandom_range(1, 500), $urandom_range(1, 32));
                default: set_config($urandom_range(0, 1), 32'd0, $urandom_range(1, 32));
            endcase
            quiet = (p == 2);
            // hold the sink off while long batches pile up behind it
            if (p == 2)
                rx_hold = HOLD_CYCLES;
            // overfill the destination store by one segment
            if (p == 4)
                run_request(SEG_DEPTH + 1, 2, 1'b0, 1'b0);
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                shape = $urandom_range(0, 9);
                noisy = ($urandom_range(0, 2) == 0);
                if (shape < 3)
                    run_request(1, 1, $urandom_range(0, 2) != 0, noisy);
                else if (shape < 8)
                    run_request($urandom_range(1, 5), $urandom_range(1, 5),
                                $urandom_range(0, 1), noisy);
                else if (shape == 8)
                    run_request($urandom_range(1, 3), $urandom_range(6, 12), 1'b0, noisy);
                else
                    run_request($urandom_range(2, 8), 1, 1'b0, noisy);
            end
        end

        quiet = 1'b0;
        settle();
        if (mismatches == 0 && pending_descr.size() == 0)
            $display("PASS scatter_gather_copy_splitter_unit");
        else
            $display("FAIL scatter_gather_copy_splitter_unit");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("FAIL scatter_gather_copy_splitter_unit");
        $finish;
    end

endmodule
